@@ rtl/q2e_pkg.sv @@
// Shared widths, types and the arctangent table for the quaternion to Euler angle block.
`default_nettype none

package q2e_pkg;

    localparam int QW         = 16;          // quaternion component, Q2.14
    localparam int ANGW       = 16;          // binary angle out
    localparam int PW         = 2 * QW;      // component product, Q.28
    localparam int FRAC2      = 28;          // fraction bits of a product
    localparam int OPW        = PW + 2;      // atan2 operand
    localparam int SW         = FRAC2 + 2;   // saturated asin argument
    localparam int SMW        = SW - 1;      // magnitude of it, also the root width
    localparam int SQW        = 2 * FRAC2 + 1; // radicand 1 - s*s
    localparam int SQ_STAGES  = (SQW + 1) / 2;
    localparam int NORM_EXP   = 40;          // operands normalised to at least 2^40
    localparam int NORM_STEPS = 7;
    localparam int MW         = NORM_EXP + 2;
    localparam int XW         = NORM_EXP + 4;
    localparam int ACCW       = 34;          // angle accumulator, 2^32 per turn
    localparam int RW         = ACCW - 16;   // rounded angle before wrap
    localparam int TAB_LEN    = 24;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int CNTW       = $clog2(FIFO_DEPTH) + 1;

    localparam logic signed [ACCW-1:0] QTURN = ACCW'(1) <<< 30;

    localparam logic signed [ACCW-1:0] ATAN_TAB [TAB_LEN] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // operands of one transaction, as queued between front and back
    typedef struct packed {
        logic signed [OPW-1:0] a1;
        logic signed [OPW-1:0] b1;
        logic signed [OPW-1:0] a3;
        logic signed [OPW-1:0] b3;
        logic signed [SW-1:0]  s;
    } ops_t;

endpackage

`default_nettype wire

@@ rtl/q2e_front.sv @@
// Front end: takes quaternions, forms the atan2 and asin operands, feeds the queue.
`default_nettype none

module q2e_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [q2e_pkg::QW-1:0] q_w,
    input  wire logic signed [q2e_pkg::QW-1:0] q_x,
    input  wire logic signed [q2e_pkg::QW-1:0] q_y,
    input  wire logic signed [q2e_pkg::QW-1:0] q_z,
    input  wire logic [q2e_pkg::CNTW-1:0]     q_count,
    output logic                              push,
    output q2e_pkg::ops_t                     push_data
);
    import q2e_pkg::*;

    localparam int OCCW = CNTW + 1;
    localparam logic signed [OPW-1:0] ONE_OP = OPW'(1) <<< FRAC2;

    logic in_acc;
    logic v1_reg, v2_reg;
    logic [OCCW-1:0] occ;
    logic signed [PW-1:0] p_ww_reg, p_xx_reg, p_zz_reg, p_wz_reg, p_xy_reg;
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xz_reg, p_wy_reg;
    logic signed [OPW-1:0] a1_c, b1_c, a3_c, b3_c, s_c;
    logic signed [SW-1:0] s_sat;
    ops_t ops2_reg;

    // count items in flight too, so the queue can never overflow
    assign occ = OCCW'(q_count) + OCCW'(v1_reg) + OCCW'(v2_reg);
    assign in_stall = (occ >= OCCW'(FIFO_DEPTH));
    assign in_acc = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        p_ww_reg <= PW'(q_w) * PW'(q_w);
        p_xx_reg <= PW'(q_x) * PW'(q_x);
        p_zz_reg <= PW'(q_z) * PW'(q_z);
        p_wz_reg <= PW'(q_w) * PW'(q_z);
        p_xy_reg <= PW'(q_x) * PW'(q_y);
        p_wx_reg <= PW'(q_w) * PW'(q_x);
        p_yz_reg <= PW'(q_y) * PW'(q_z);
        p_xz_reg <= PW'(q_x) * PW'(q_z);
        p_wy_reg <= PW'(q_w) * PW'(q_y);
    end

    assign a1_c = (OPW'(p_wz_reg) + OPW'(p_xy_reg)) <<< 1;
    assign b1_c = ((OPW'(p_ww_reg) + OPW'(p_xx_reg)) <<< 1) - ONE_OP;
    assign a3_c = (OPW'(p_wx_reg) + OPW'(p_yz_reg)) <<< 1;
    assign b3_c = ((OPW'(p_ww_reg) + OPW'(p_zz_reg)) <<< 1) - ONE_OP;
    assign s_c  = -((OPW'(p_xz_reg) - OPW'(p_wy_reg)) <<< 1);

    always_comb
    begin
        if (s_c > ONE_OP)
        begin
            s_sat = SW'(ONE_OP);
        end
        else if (s_c < -ONE_OP)
        begin
            s_sat = SW'(-ONE_OP);
        end
        else
        begin
            s_sat = SW'(s_c);
        end
    end

    always_ff @(posedge clk)
    begin
        ops2_reg.a1 <= a1_c;
        ops2_reg.b1 <= b1_c;
        ops2_reg.a3 <= a3_c;
        ops2_reg.b3 <= b3_c;
        ops2_reg.s  <= s_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_acc;
            v2_reg <= v1_reg;
        end
    end

    assign push      = v2_reg;
    assign push_data = ops2_reg;

endmodule

`default_nettype wire

@@ rtl/q2e_fifo.sv @@
// Short operand queue between the front end and the angle pipeline.
`default_nettype none

module q2e_fifo (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  q2e_pkg::ops_t                 push_data,
    input  wire logic                     pop,
    output q2e_pkg::ops_t                 pop_data,
    output logic [q2e_pkg::CNTW-1:0]      count
);
    import q2e_pkg::*;

    localparam int PTRW = $clog2(FIFO_DEPTH);

    ops_t mem_reg [FIFO_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count_next = count_reg + CNTW'(push) - CNTW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNTW'(FIFO_DEPTH)))
        else $error("operand queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("operand queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("queue count lost a write");

endmodule

`default_nettype wire

@@ rtl/q2e_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module q2e_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [q2e_pkg::SQW-1:0]       rad,
    output logic [q2e_pkg::SMW-1:0]            root
);
    import q2e_pkg::*;

    localparam int RRW = SQW + 1;

    logic [RRW-1:0] rem_reg [SQ_STAGES-1];
    logic [RRW-1:0] res_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        localparam logic [RRW-1:0] BITV = RRW'(1) << (2 * (SQ_STAGES - 1 - k));
        logic [RRW-1:0] rem_in, res_in, trial;
        logic           fits;

        if (k == 0)
        begin : g_first
            assign rem_in = RRW'(rad);
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + BITV;
        assign fits  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[k] <= fits ? ((res_in >> 1) + BITV) : (res_in >> 1);
            end
        end

        if (k < SQ_STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = res_reg[SQ_STAGES-1][SMW-1:0];

endmodule

`default_nettype wire

@@ rtl/q2e_cordic.sv @@
// Pipelined vectoring CORDIC atan2: half-plane fold, normalise, iterate, round.
`default_nettype none

module q2e_cordic #(
    parameter int NIT = q2e_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [q2e_pkg::OPW-1:0] y_in,
    input  wire logic signed [q2e_pkg::OPW-1:0] x_in,
    output logic signed [q2e_pkg::RW-1:0]      r_out
);
    import q2e_pkg::*;

    localparam int TOT = NORM_STEPS + 1 + NIT;
    localparam logic signed [ACCW-1:0] HALF_LSB = ACCW'(1) <<< (ACCW - RW - 1);

    logic signed [XW-1:0]   sx_reg   [TOT];
    logic signed [XW-1:0]   sy_reg   [TOT];
    logic signed [ACCW-1:0] sacc_reg [TOT];
    logic                   sz_reg   [TOT];
    logic [MW-1:0]          sm_reg   [NORM_STEPS];
    logic signed [RW-1:0]   r_reg;

    logic signed [XW-1:0]   xe, ye, xp, yp, ax, ay;
    logic signed [ACCW-1:0] acc0;
    logic signed [ACCW-1:0] acc_rnd;

    // fold the left half plane onto the right by a quarter turn
    always_comb
    begin
        xe   = XW'(x_in);
        ye   = XW'(y_in);
        xp   = xe;
        yp   = ye;
        acc0 = '0;
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                acc0 = QTURN;
                xp   = ye;
                yp   = -xe;
            end
            else
            begin
                acc0 = -QTURN;
                xp   = -ye;
                yp   = xe;
            end
        end
        ax = (xp < 0) ? -xp : xp;
        ay = (yp < 0) ? -yp : yp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg[0]   <= xp;
            sy_reg[0]   <= yp;
            sacc_reg[0] <= acc0;
            sz_reg[0]   <= (x_in == '0) && (y_in == '0);
            sm_reg[0]   <= MW'((ax > ay) ? ax : ay);
        end
    end

    // binary search for the doubling count, then one last doubling
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam bit LAST = (j == NORM_STEPS - 1);
        localparam int SH   = LAST ? 1 : (1 << (NORM_STEPS - 2 - j));
        localparam logic [MW-1:0] LIM = MW'(1) << (LAST ? NORM_EXP : (NORM_EXP - SH));
        logic go;

        assign go = (sm_reg[j] < LIM);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sx_reg[j+1]   <= go ? (sx_reg[j] <<< SH) : sx_reg[j];
                sy_reg[j+1]   <= go ? (sy_reg[j] <<< SH) : sy_reg[j];
                sacc_reg[j+1] <= sacc_reg[j];
                sz_reg[j+1]   <= sz_reg[j];
            end
        end

        if (!LAST)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sm_reg[j+1] <= go ? (sm_reg[j] << SH) : sm_reg[j];
                end
            end
        end
    end

    for (genvar i = 0; i < NIT; i++)
    begin : g_iter
        localparam int B = NORM_STEPS + i;
        logic signed [XW-1:0] xs, ys;

        assign xs = sx_reg[B] >>> i;
        assign ys = sy_reg[B] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sy_reg[B] > 0)
                begin
                    sx_reg[B+1]   <= sx_reg[B] + ys;
                    sy_reg[B+1]   <= sy_reg[B] - xs;
                    sacc_reg[B+1] <= sacc_reg[B] + ATAN_TAB[i];
                end
                else
                begin
                    sx_reg[B+1]   <= sx_reg[B] - ys;
                    sy_reg[B+1]   <= sy_reg[B] + xs;
                    sacc_reg[B+1] <= sacc_reg[B] - ATAN_TAB[i];
                end
                sz_reg[B+1] <= sz_reg[B];
            end
        end
    end

    assign acc_rnd = sacc_reg[TOT-1] + HALF_LSB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= sz_reg[TOT-1] ? '0 : acc_rnd[ACCW-1:ACCW-RW];
        end
    end

    assign r_out = r_reg;

endmodule

`default_nettype wire

@@ rtl/q2e_back.sv @@
// Back end: asin cosine via square root, three CORDICs, output register.
`default_nettype none

module q2e_back #(
    parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_avail,
    input  q2e_pkg::ops_t                        pop_data,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_first,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_second,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_third
);
    import q2e_pkg::*;

    localparam int NIT = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int CL  = NIT + NORM_STEPS + 2;
    localparam int LB  = 3 + SQ_STAGES + CL + 1;
    localparam logic signed [RW-1:0] P_MAX = RW'(1) <<< (ANGW - 2);
    localparam logic [SQW-1:0] RAD_ONE = SQW'(1) << (2 * FRAC2);
    localparam logic signed [ANGW-1:0] A_MAX = ANGW'(1) <<< (ANGW - 2);

    logic            adv;
    logic [LB-1:0]   vld_reg;
    ops_t            ops_a_reg, ops_b_reg, ops_c_reg;
    ops_t            dly_reg [SQ_STAGES];
    logic [SMW-1:0]  s_mag;
    logic [SQW-1:0]  s2_reg, rad_reg;
    logic [SMW-1:0]  root;
    logic signed [OPW-1:0] p_y, p_x;
    logic signed [RW-1:0]  r1, r2, r3;
    logic signed [ANGW-1:0] a1_reg, a2_reg, a3_reg;

    // whole pipeline moves unless a finished result is held
    assign adv = !(vld_reg[LB-1] && out_stall);
    assign pop = q_avail && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LB-2:0], pop};
        end
    end

    assign s_mag = SMW'(ops_a_reg.s[SW-1] ? -ops_a_reg.s : ops_a_reg.s);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ops_a_reg <= pop_data;
            ops_b_reg <= ops_a_reg;
            s2_reg    <= SQW'(s_mag) * SQW'(s_mag);
            ops_c_reg <= ops_b_reg;
            rad_reg   <= RAD_ONE - s2_reg;
            dly_reg[0] <= ops_c_reg;
        end
    end

    for (genvar k = 1; k < SQ_STAGES; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    q2e_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    assign p_y = OPW'(dly_reg[SQ_STAGES-1].s);
    assign p_x = signed'(OPW'(root));

    q2e_cordic #(.NIT(NIT)) u_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (dly_reg[SQ_STAGES-1].a1),
        .x_in  (dly_reg[SQ_STAGES-1].b1),
        .r_out (r1)
    );

    q2e_cordic #(.NIT(NIT)) u_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (p_y),
        .x_in  (p_x),
        .r_out (r2)
    );

    q2e_cordic #(.NIT(NIT)) u_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (dly_reg[SQ_STAGES-1].a3),
        .x_in  (dly_reg[SQ_STAGES-1].b3),
        .r_out (r3)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= r1[ANGW-1:0];
            a3_reg <= r3[ANGW-1:0];
            if (r2 > P_MAX)
            begin
                a2_reg <= ANGW'(P_MAX);
            end
            else if (r2 < -P_MAX)
            begin
                a2_reg <= ANGW'(-P_MAX);
            end
            else
            begin
                a2_reg <= r2[ANGW-1:0];
            end
        end
    end

    assign out_valid    = vld_reg[LB-1];
    assign angle_first  = a1_reg;
    assign angle_second = a2_reg;
    assign angle_third  = a3_reg;

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((angle_second <= A_MAX) && (angle_second >= -A_MAX)))
        else $error("pitch outside a right angle");

endmodule

`default_nettype wire

@@ rtl/quaternion_to_euler_angles_top.sv @@
// Top level: quaternion (Q2.14) to Z-Y-X Euler binary angles.
// Throughput: one transaction per cycle while out_stall is low; square root, CORDICs are fully pipelined.
// Input stalls only when the four-entry queue plus front stages would overflow.
// Reset (rst_n, asynchronous, active low) clears valids, queue pointers and queue count only.
// No clearing pass and no state between transactions.
`default_nettype none

module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [q2e_pkg::QW-1:0]   q_w,
    input  wire logic signed [q2e_pkg::QW-1:0]   q_x,
    input  wire logic signed [q2e_pkg::QW-1:0]   q_y,
    input  wire logic signed [q2e_pkg::QW-1:0]   q_z,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_first,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_second,
    output logic signed [q2e_pkg::ANGW-1:0]      angle_third
);
    import q2e_pkg::*;

    // front: products and operand formation, two register stages
    ops_t             push_data, pop_data;
    logic             push, pop;
    logic [CNTW-1:0]  q_count;

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_w       (q_w),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    // queue decouples front from the long back pipeline
    q2e_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    // back: sqrt for the pitch cosine, three CORDICs, clamp, output register
    q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_count != '0),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .angle_first  (angle_first),
        .angle_second (angle_second),
        .angle_third  (angle_third)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_quaternion_to_euler_angles_top.sv @@
// Self-checking testbench for the quaternion to Z-Y-X Euler angle block.
module tb_quaternion_to_euler_angles_top;
    import q2e_pkg::*;

    localparam int STAGES      = DEF_CORDIC_STAGES;
    localparam int LATENCY     = STAGES + 44;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam longint ONE_Q28 = 64'sd1 <<< 28;
    localparam longint NORM_MIN = 64'sd1 <<< 40;

    typedef struct {
        logic signed [QW-1:0] w, x, y, z;
    } quat_t;

    typedef struct {
        logic signed [ANGW-1:0] yaw, pitch, roll;
    } euler_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [QW-1:0] q_w, q_x, q_y, q_z;
    logic out_valid;
    logic out_stall;
    logic signed [ANGW-1:0] angle_first, angle_second, angle_third;

    quat_t  quat_pending[$];   // filled by the stimulus block, drained by the driver
    euler_t euler_expected[$]; // one entry per accepted transaction
    int     errors;
    int     n_accepted;
    int     n_checked;
    int     cycles;
    bit     send_no_gaps;      // driver runs flat out while set
    bit     recv_no_gaps;      // monitor adds no random wait while set; long_hold can still stall it
    bit     long_hold;         // receiver held off for a long stretch

    quaternion_to_euler_angles_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .q_w          (q_w),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_z          (q_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .angle_first  (angle_first),
        .angle_second (angle_second),
        .angle_third  (angle_third)
    );

    // ------------------------------------------------------------------
    // Predictor: vectoring CORDIC, angle accumulator in 2^32 units per turn
    // ------------------------------------------------------------------
    function automatic longint cordic_angle(longint ay, longint ax);
        longint acc;
        longint t;
        longint m;
        longint xs;
        longint ys;
        int     n;
        acc = 0;
        if (ax == 0 && ay == 0)
            return 0;
        // left half plane: quarter turn first so CORDIC converges
        if (ax < 0) begin
            if (ay >= 0) begin
                acc = 64'sd1 <<< 30;
                t = ax; ax = ay; ay = -t;
            end
            else begin
                acc = -(64'sd1 <<< 30);
                t = ax; ax = -ay; ay = t;
            end
        end
        m = ((ax < 0) ? -ax : ax);
        if (((ay < 0) ? -ay : ay) > m)
            m = (ay < 0) ? -ay : ay;
        while (m < NORM_MIN) begin
            ax = ax * 2; ay = ay * 2; m = m * 2;
        end
        n = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;
        for (int i = 0; i < n; i++) begin
            xs = ax >>> i;
            ys = ay >>> i;
            if (ay > 0) begin
                ax = ax + ys; ay = ay - xs; acc = acc + longint'(ATAN_TAB[i]);
            end
            else begin
                ax = ax - ys; ay = ay + xs; acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint round_to_binang(longint acc);
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic euler_t euler_predict(quat_t q);
        longint w, x, y, z;
        longint a1, b1, a3, b3, s, c, r2;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        a1 = 2 * (w * z + x * y);
        b1 = 2 * (w * w + x * x) - ONE_Q28;
        a3 = 2 * (w * x + y * z);
        b3 = 2 * (w * w + z * z) - ONE_Q28;
        s  = -2 * (x * z - w * y);
        // asin argument saturates at +-1.0
        if (s > ONE_Q28)  s = ONE_Q28;
        if (s < -ONE_Q28) s = -ONE_Q28;
        c = longint'(root_floor(longint'(ONE_Q28 * ONE_Q28) - s * s));
        r2 = round_to_binang(cordic_angle(s, c));
        // pitch clamped to a right angle
        if (r2 > 16384)  r2 = 16384;
        if (r2 < -16384) r2 = -16384;
        e.yaw   = ANGW'(round_to_binang(cordic_angle(a1, b1)));
        e.pitch = ANGW'(r2);
        e.roll  = ANGW'(round_to_binang(cordic_angle(a3, b3)));
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions still awaited", $realtime,
                     euler_expected.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: one pending quaternion at a time, random gap before each
    // ------------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n) begin
        bit    occupied;
        bit    next_valid;
        quat_t q;
        if (!rst_n) begin
            in_valid <= 1'b0;
            q_w <= '0; q_x <= '0; q_y <= '0; q_z <= '0;
            send_gap <= 0;
        end
        else begin
            occupied   = in_valid;
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                q.w = q_w; q.x = q_x; q.y = q_y; q.z = q_z;
                euler_expected.push_back(euler_predict(q));
                n_accepted <= n_accepted + 1;
                occupied   = 1'b0;
                next_valid = 1'b0;
            end
            // payload held steady while stalled
            if (!occupied) begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (quat_pending.size() > 0) begin
                    q = quat_pending.pop_front();
                    q_w <= q.w; q_x <= q.x; q_y <= q.y; q_z <= q.z;
                    next_valid = 1'b1;
                    send_gap <= send_no_gaps ? 0 : $urandom_range(0, 11);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    int recv_wait;

    always @(posedge clk or negedge rst_n) begin
        euler_t e;
        int     w;
        int     bad;
        if (!rst_n) begin
            out_stall <= 1'b1;
            recv_wait <= 0;
        end
        else begin
            w = recv_wait;
            bad = 0;
            if (out_valid && !out_stall) begin
                n_checked <= n_checked + 1;
                if (euler_expected.size() == 0) begin
                    $display("%0t: unexpected result yaw=%0d pitch=%0d roll=%0d", $realtime,
                             angle_first, angle_second, angle_third);
                    bad = bad + 1;
                end
                else begin
                    e = euler_expected.pop_front();
                    if (angle_first !== e.yaw) begin
                        $display("%0t: angle_first expected %0d actual %0d", $realtime,
                                 e.yaw, angle_first);
                        bad = bad + 1;
                    end
                    if (angle_second !== e.pitch) begin
                        $display("%0t: angle_second expected %0d actual %0d", $realtime,
                                 e.pitch, angle_second);
                        bad = bad + 1;
                    end
                    if (angle_third !== e.roll) begin
                        $display("%0t: angle_third expected %0d actual %0d", $realtime,
                                 e.roll, angle_third);
                        bad = bad + 1;
                    end
                end
                w = recv_no_gaps ? 0 : $urandom_range(0, 11);
            end
            else if (w > 0)
                w = w - 1;
            if (bad > 0)
                errors <= errors + bad;
            recv_wait <= w;
            out_stall <= long_hold || (w > 0);
        end
    end

    // Long hold-off on the output side so the internal queue fills and
    // in_stall rises while the driver keeps offering transactions.
    always @(posedge clk or negedge rst_n) begin
        int hold_cnt;
        if (!rst_n) begin
            long_hold <= 1'b0;
            hold_cnt = 0;
        end
        else if (hold_cnt == 0 && n_accepted >= 300 && n_accepted < 310) begin
            long_hold <= 1'b1;
            hold_cnt = 400;
        end
        else if (hold_cnt > 1)
            hold_cnt = hold_cnt - 1;
        else if (hold_cnt == 1) begin
            long_hold <= 1'b0;
            hold_cnt = -1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic add_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = QW'(w); q.x = QW'(x); q.y = QW'(y); q.z = QW'(z);
        quat_pending.push_back(q);
    endtask

    // near-unit quaternion with random content
    task automatic add_unit_quat();
        int  x, y, z;
        real r;
        x = $urandom_range(0, 18918) - 9459;
        y = $urandom_range(0, 18918) - 9459;
        z = $urandom_range(0, 18918) - 9459;
        r = $sqrt(268435456.0 - real'(x * x + y * y + z * z));
        if ($urandom_range(0, 1))
            add_quat(int'(r), x, y, z);
        else
            add_quat(-int'(r), x, y, z);
    endtask

    initial begin
        int kind;
        errors = 0; n_accepted = 0; n_checked = 0; cycles = 0;
        send_no_gaps = 1'b0;
        recv_no_gaps = 1'b0;
        rst_n = 1'b0;

        // directed: identity, zero (atan2 of 0,0), extremes, gimbal lock,
        // asin saturation, left half plane, non-unit input
        add_quat(16384, 0, 0, 0);
        add_quat(-16384, 0, 0, 0);
        add_quat(0, 0, 0, 0);
        add_quat(0, 16384, 0, 0);
        add_quat(0, 0, 16384, 0);
        add_quat(0, 0, 0, 16384);
        add_quat(11585, 0, 11585, 0);
        add_quat(11585, 0, -11585, 0);
        add_quat(11585, 11585, 0, 0);
        add_quat(11585, 0, 0, 11585);
        add_quat(11585, 0, 0, -11585);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, 0, 32767, 0);
        add_quat(-32768, 0, 32767, 0);
        add_quat(0, 11585, 0, 11585);
        add_quat(8192, 8192, 8192, 8192);
        add_quat(-8192, 8192, -8192, 8192);
        add_quat(100, -3, 2, -1);
        add_quat(1, 0, 0, 0);
        add_quat(0, 0, 1, -1);
        add_quat(16384, 1, -1, 1);

        // random part: mostly unit quaternions, some raw full-range noise and small values
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                add_unit_quat();
            else if (kind < 9)
                add_quat($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            else
                add_quat($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                         $urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // alternate between random gaps and back-to-back stretches
        while (quat_pending.size() > 0) begin
            repeat (150) @(posedge clk);
            send_no_gaps <= ~send_no_gaps;
            recv_no_gaps <= ($urandom_range(0, 2) == 0);
        end
        while (in_valid || euler_expected.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("Checked %0d of %0d transactions: corner quaternions, unit and raw inputs,",
                 n_checked, n_accepted);
        $display("random gaps on both sides and a long output hold-off; %0d errors.", errors);
        if (errors == 0 && euler_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_fifo.sv
rtl/q2e_sqrt.sv
rtl/q2e_cordic.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler_angles_top.sv
tb/sv/tb_quaternion_to_euler_angles_top.sv
